/* rtl/bdr_pkg.sv */
package bdr_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int CMD_W         = 3;
   localparam int STATUS_W      = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_REPLACE    = 3'd4,
      CMD_DUMP       = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_NOTFOUND = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_READ,
      CS_POP,
      CS_MATCH,
      CS_DUMP
   } ctl_state_type;

   typedef enum logic [2:0] {
      ADDR_FRONT_PREV,
      ADDR_TAIL,
      ADDR_FRONT,
      ADDR_LAST,
      ADDR_SCAN
   } addr_sel_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic {
      WR_VALUE,
      WR_NEW
   } wr_src_type;

   typedef enum logic [1:0] {
      OUT_VALUE,
      OUT_READ,
      OUT_NEW,
      OUT_ZERO
   } out_src_type;

   typedef struct packed {
      logic         latch;
      logic         mem_wr;
      wr_src_type   wr_src;
      addr_sel_type addr_sel;
      logic         rd_en;
      ptr_op_type   front_op;
      ptr_op_type   occ_op;
      logic         scan_init;
      logic         scan_step;
      logic         out_load;
      out_src_type  out_src;
      status_type   out_status;
      logic         out_last;
   } dp_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic match;
      logic scan_last;
      logic out_free;
   } dp_sts_type;

endpackage

/* rtl/bdr_if.sv */
interface bdr_req_if;
   logic                                valid;
   logic                                ready;
   logic [bdr_pkg::CMD_W-1:0]           cmd;
   logic signed [bdr_pkg::DATA_W-1:0]   value;
   logic signed [bdr_pkg::DATA_W-1:0]   new_value;

   modport source (output valid, output cmd, output value, output new_value, input ready);
   modport sink   (input valid, input cmd, input value, input new_value, output ready);
endinterface

interface bdr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bdr_pkg::STATUS_W-1:0]        status;
   logic signed [bdr_pkg::DATA_W-1:0]   data;
   logic                                last;

   modport source (output valid, output status, output data, output last, input ready);
   modport sink   (input valid, input status, input data, input last, output ready);
endinterface

/* rtl/bdr_dpath.sv */
module bdr_dpath #(
   parameter int DEPTH = bdr_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bdr_pkg::dp_ctl_type               ctl,
   output bdr_pkg::dp_sts_type               sts,
   input  logic signed [bdr_pkg::DATA_W-1:0] req_value,
   input  logic signed [bdr_pkg::DATA_W-1:0] req_new_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bdr_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [bdr_pkg::DATA_W-1:0] rsp_data,
   output logic                              rsp_last
);
   import bdr_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W:0]   DEPTH_S  = (CNT_W + 1)'(DEPTH);

   logic [DATA_W-1:0] mem [DEPTH];

   logic [IDX_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [IDX_W-1:0]  pos_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [DATA_W-1:0] key_ff, nval_ff, rd_ff;
   logic              out_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic              out_last_ff;

   logic [CNT_W:0]    tail_sum;
   logic [IDX_W-1:0]  tail, last_idx, front_prev, front_next, pos_next, addr;
   logic [DATA_W-1:0] wr_data, out_data_in;
   logic              out_free;

   always_comb begin
      tail_sum   = (CNT_W + 1)'(front_ff) + (CNT_W + 1)'(occ_ff);
      tail       = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
      last_idx   = (tail == '0) ? IDX_MAX : tail - 1'b1;
      front_prev = (front_ff == '0) ? IDX_MAX : front_ff - 1'b1;
      front_next = (front_ff == IDX_MAX) ? '0 : front_ff + 1'b1;
      pos_next   = (pos_ff == IDX_MAX) ? '0 : pos_ff + 1'b1;
   end

   always_comb begin
      case (ctl.addr_sel)
         ADDR_FRONT_PREV: addr = front_prev;
         ADDR_TAIL:       addr = tail;
         ADDR_FRONT:      addr = front_ff;
         ADDR_LAST:       addr = last_idx;
         ADDR_SCAN:       addr = pos_ff;
         default:         addr = pos_ff;
      endcase
   end

   assign wr_data = (ctl.wr_src == WR_NEW) ? nval_ff : req_value;

   always_ff @(posedge clock) begin
      if (ctl.mem_wr) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   always_comb begin
      case (ctl.front_op)
         PTR_INC: front_in = front_next;
         PTR_DEC: front_in = front_prev;
         default: front_in = front_ff;
      endcase
      case (ctl.occ_op)
         PTR_INC: occ_in = occ_ff + 1'b1;
         PTR_DEC: occ_in = occ_ff - 1'b1;
         default: occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         occ_ff   <= '0;
      end else begin
         front_ff <= front_in;
         occ_ff   <= occ_in;
      end
   end

   // scan walks the ring from the front; rem counts entries still to visit
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         key_ff  <= req_value;
         nval_ff <= req_new_value;
      end
      if (ctl.scan_init) begin
         pos_ff <= front_ff;
         rem_ff <= occ_ff;
      end else if (ctl.scan_step) begin
         pos_ff <= pos_next;
         rem_ff <= rem_ff - 1'b1;
      end
   end

   always_comb begin
      case (ctl.out_src)
         OUT_VALUE: out_data_in = req_value;
         OUT_READ:  out_data_in = rd_ff;
         OUT_NEW:   out_data_in = nval_ff;
         default:   out_data_in = '0;
      endcase
   end

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         out_status_ff <= ctl.out_status;
         out_data_ff   <= out_data_in;
         out_last_ff   <= ctl.out_last;
      end
   end

   assign sts.full      = (occ_ff == CNT_FULL);
   assign sts.empty     = (occ_ff == '0);
   assign sts.match     = (rd_ff == key_ff);
   assign sts.scan_last = (rem_ff == CNT_W'(1));
   assign sts.out_free  = out_free;

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_data   = out_data_ff;
   assign rsp_last   = out_last_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_FULL) else $error("occupancy beyond depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= IDX_MAX) else $error("front index out of ring");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> out_free) else $error("result beat overwritten before taken");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (ctl.mem_wr && ctl.wr_src == WR_VALUE) |-> occ_ff != CNT_FULL)
      else $error("push written into full queue");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && occ_ff != $past(occ_ff) |->
         (occ_ff == $past(occ_ff) + 1'b1) || (occ_ff == $past(occ_ff) - 1'b1))
      else $error("occupancy jumped");

endmodule

/* rtl/bdr_ctrl.sv */
module bdr_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [bdr_pkg::CMD_W-1:0]  req_cmd,
   output logic                       req_ready,
   input  bdr_pkg::dp_sts_type        sts,
   output bdr_pkg::dp_ctl_type        ctl
);
   import bdr_pkg::*;

   ctl_state_type state_ff, state_in;
   cmd_type       op_ff, op_in;
   cmd_type       cmd;
   logic          fire;

   assign cmd = cmd_type'(req_cmd);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      req_ready      = 1'b0;
      fire           = 1'b0;
      ctl.latch      = 1'b0;
      ctl.mem_wr     = 1'b0;
      ctl.wr_src     = WR_VALUE;
      ctl.addr_sel   = ADDR_SCAN;
      ctl.rd_en      = 1'b0;
      ctl.front_op   = PTR_HOLD;
      ctl.occ_op     = PTR_HOLD;
      ctl.scan_init  = 1'b0;
      ctl.scan_step  = 1'b0;
      ctl.out_load   = 1'b0;
      ctl.out_src    = OUT_ZERO;
      ctl.out_status = STAT_OK;
      ctl.out_last   = 1'b1;

      case (state_ff)
         CS_IDLE: begin
            req_ready = sts.out_free;
            fire      = req_valid && sts.out_free;
            if (fire) begin
               ctl.latch = 1'b1;
               op_in     = cmd;
               case (cmd)
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     ctl.out_load = 1'b1;
                     if (sts.full) begin
                        ctl.out_status = STAT_FULL;
                     end else begin
                        ctl.mem_wr   = 1'b1;
                        ctl.addr_sel = (cmd == CMD_PUSH_FRONT) ? ADDR_FRONT_PREV : ADDR_TAIL;
                        ctl.front_op = (cmd == CMD_PUSH_FRONT) ? PTR_DEC : PTR_HOLD;
                        ctl.occ_op   = PTR_INC;
                        ctl.out_src  = OUT_VALUE;
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (sts.empty) begin
                        ctl.out_load   = 1'b1;
                        ctl.out_status = STAT_EMPTY;
                     end else begin
                        ctl.rd_en    = 1'b1;
                        ctl.addr_sel = (cmd == CMD_POP_FRONT) ? ADDR_FRONT : ADDR_LAST;
                        ctl.front_op = (cmd == CMD_POP_FRONT) ? PTR_INC : PTR_HOLD;
                        ctl.occ_op   = PTR_DEC;
                        state_in     = CS_POP;
                     end
                  end
                  CMD_REPLACE, CMD_DUMP: begin
                     if (sts.empty) begin
                        ctl.out_load   = 1'b1;
                        ctl.out_status = (cmd == CMD_REPLACE) ? STAT_NOTFOUND : STAT_EMPTY;
                     end else begin
                        ctl.scan_init = 1'b1;
                        state_in      = CS_READ;
                     end
                  end
                  default: begin
                     // undefined codes are dropped without a beat
                  end
               endcase
            end
         end
         CS_READ: begin
            ctl.rd_en    = 1'b1;
            ctl.addr_sel = ADDR_SCAN;
            state_in     = (op_ff == CMD_REPLACE) ? CS_MATCH : CS_DUMP;
         end
         CS_POP: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               ctl.out_src  = OUT_READ;
               state_in     = CS_IDLE;
            end
         end
         CS_MATCH: begin
            if (sts.match) begin
               if (sts.out_free) begin
                  ctl.mem_wr   = 1'b1;
                  ctl.wr_src   = WR_NEW;
                  ctl.addr_sel = ADDR_SCAN;
                  ctl.out_load = 1'b1;
                  ctl.out_src  = OUT_NEW;
                  state_in     = CS_IDLE;
               end
            end else if (sts.scan_last) begin
               if (sts.out_free) begin
                  ctl.out_load   = 1'b1;
                  ctl.out_status = STAT_NOTFOUND;
                  state_in       = CS_IDLE;
               end
            end else begin
               ctl.scan_step = 1'b1;
               state_in      = CS_READ;
            end
         end
         CS_DUMP: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               ctl.out_src  = OUT_READ;
               ctl.out_last = sts.scan_last;
               if (sts.scan_last) begin
                  state_in = CS_IDLE;
               end else begin
                  ctl.scan_step = 1'b1;
                  state_in      = CS_READ;
               end
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == CS_IDLE) else $error("command taken while busy");

   a_scan_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == CS_READ |=> (state_ff == CS_MATCH || state_ff == CS_DUMP))
      else $error("scan read not followed by check");

   a_dump_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_DUMP && ctl.out_load && ctl.out_last) |=> state_ff == CS_IDLE)
      else $error("dump kept going after last beat");

endmodule

/* rtl/bounded_deque_with_replace.sv */
// Channel  Dir  Beat carries                       Accepted when
// req_bus  in   cmd, value, new_value              req_bus.valid && req_bus.ready
// rsp_bus  out  status, data, last                 rsp_bus.valid && rsp_bus.ready
//
// Push, unknown codes and any command refused on an empty or full queue end in the
// accepting state. Pop reads there and returns from CS_POP. Replace and Dump read
// each entry from the front in CS_READ, then compare it in CS_MATCH or return it in
// CS_DUMP, since the entry memory has a single registered read port.
// Synchronous reset empties the queue; entries are undefined until written.
// A stalled result holds its register; a new command is taken once it drains.
module bounded_deque_with_replace #(
   parameter int DEPTH = bdr_pkg::DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bdr_req_if.sink   req_bus,
   bdr_rsp_if.source rsp_bus
);
   import bdr_pkg::*;

   dp_ctl_type ctl;
   dp_sts_type sts;

   bdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_bus.cmd),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   bdr_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .req_value     (req_bus.value),
      .req_new_value (req_bus.new_value),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_status    (rsp_bus.status),
      .rsp_data      (rsp_bus.data),
      .rsp_last      (rsp_bus.last)
   );

endmodule
